@@ src/btlc_pkg.sv @@
// ----------------------------------------------------------------------------
// Button timed light controller package
// Shared widths, event codes and the structs passed between the modules.
// ----------------------------------------------------------------------------
package btlc_pkg;

	localparam int COUNT_W = 16;
	localparam int CFG_W   = 16;
	localparam int CMP_W   = (COUNT_W > CFG_W) ? COUNT_W : CFG_W;
	localparam int IDX_W   = 4;

	typedef logic [2:0]         event_t;
	typedef logic [COUNT_W-1:0] count_t;
	typedef logic [CFG_W-1:0]   cfg_word_t;
	typedef logic [IDX_W-1:0]   cfg_idx_t;

	localparam event_t EV_NONE      = 3'd0;
	localparam event_t EV_ON        = 3'd1;
	localparam event_t EV_RESTART   = 3'd2;
	localparam event_t EV_CYCLE_ON  = 3'd3;
	localparam event_t EV_CYCLE_OFF = 3'd4;
	localparam event_t EV_TIMEOUT   = 3'd5;

	localparam cfg_idx_t REG_HOLD_TICKS = 4'd0;
	localparam cfg_idx_t REG_ON_TICKS   = 4'd1;

	localparam cfg_word_t HOLD_TICKS_RST = 16'd100;
	localparam cfg_word_t ON_TICKS_RST   = 16'd500;

	typedef struct packed {
		cfg_word_t hold_ticks;
		cfg_word_t on_ticks;
	} cfg_t;

	typedef struct packed {
		logic   light_on;
		event_t event_code;
	} result_t;

endpackage

@@ src/btlc_if.sv @@
// ----------------------------------------------------------------------------
// Button timed light controller channels
// Valid/ready channels for button samples, results and register writes.
// ----------------------------------------------------------------------------
interface btlc_in_if;
	logic valid;
	logic ready;
	logic button_pressed;

	modport source (output valid, output button_pressed, input ready);
	modport sink (input valid, input button_pressed, output ready);
endinterface

interface btlc_out_if;
	logic              valid;
	logic              ready;
	logic              light_on;
	btlc_pkg::event_t  event_code;

	modport source (output valid, output light_on, output event_code, input ready);
	modport sink (input valid, input light_on, input event_code, output ready);
endinterface

interface btlc_cfg_if;
	logic                valid;
	logic                ready;
	btlc_pkg::cfg_idx_t  index;
	btlc_pkg::cfg_word_t data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

@@ src/button_timed_light_controller.sv @@
// ----------------------------------------------------------------------------
// Button timed light controller
// Push-button light control with hold toggling and an on-time timer.
// ----------------------------------------------------------------------------
//  port     role    payload
//  button   sink    button_pressed
//  result   source  light_on, event_code
//  cfg      sink    index, data (hold_ticks = 0, on_ticks = 1)
//
// One sample is taken every cycle while the result is not stalled; each
// accepted request passes through the sample register and then the result
// register, and the controller state is updated as a sample moves between
// them. Reset clears the light, the press and timer state and loads the
// default thresholds. A stalled result holds the sample register, which
// stops new requests once both stages are full.
// ----------------------------------------------------------------------------
module button_timed_light_controller (
	input  logic          clk,
	input  logic          arst_n,
	btlc_in_if.sink       button,
	btlc_out_if.source    result,
	btlc_cfg_if.sink      cfg
);

	btlc_pkg::cfg_t    regs;
	btlc_pkg::result_t res_n;
	btlc_pkg::result_t res_q;
	logic              valid_s1;
	logic              btn_s1;
	logic              out_valid_q;
	logic              in_acc;
	logic              adv;

	assign adv          = valid_s1 && (!out_valid_q || result.ready);
	assign button.ready = !valid_s1 || adv;
	assign in_acc       = button.valid && button.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			btn_s1 <= button.button_pressed;
		end
		if (adv) begin
			res_q <= res_n;
		end
	end

	btlc_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	btlc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv),
		.btn    (btn_s1),
		.regs   (regs),
		.res    (res_n)
	);

	assign result.valid      = out_valid_q;
	assign result.light_on   = res_q.light_on;
	assign result.event_code = res_q.event_code;

endmodule

@@ src/btlc_cfg.sv @@
// ----------------------------------------------------------------------------
// Button timed light controller registers
// Holds the hold and on-time thresholds written through the register port.
// ----------------------------------------------------------------------------
module btlc_cfg (
	input  logic            clk,
	input  logic            arst_n,
	btlc_cfg_if.sink        cfg,
	output btlc_pkg::cfg_t  regs
);

	btlc_pkg::cfg_word_t hold_q;
	btlc_pkg::cfg_word_t on_q;
	logic                wr;

	assign cfg.ready = 1'b1;
	assign wr = cfg.valid && cfg.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= btlc_pkg::HOLD_TICKS_RST;
			on_q   <= btlc_pkg::ON_TICKS_RST;
		end else if (wr) begin
			case (cfg.index)
				btlc_pkg::REG_HOLD_TICKS: hold_q <= cfg.data;
				btlc_pkg::REG_ON_TICKS:   on_q   <= cfg.data;
				default: ;
			endcase
		end
	end

	assign regs.hold_ticks = hold_q;
	assign regs.on_ticks   = on_q;

endmodule

@@ src/btlc_core.sv @@
// ----------------------------------------------------------------------------
// Button timed light controller core
// Controller state and the per-tick update that yields one result.
// ----------------------------------------------------------------------------
module btlc_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic              btn,
	input  btlc_pkg::cfg_t    regs,
	output btlc_pkg::result_t res
);

	localparam int CMP_W = btlc_pkg::CMP_W;

	logic             light_q;
	logic             pressing_q;
	logic             cycling_q;
	logic             timer_run_q;
	btlc_pkg::count_t press_cnt_q;
	btlc_pkg::count_t timer_cnt_q;

	logic             light_n;
	logic             pressing_n;
	logic             cycling_n;
	logic             timer_run_n;
	btlc_pkg::count_t press_cnt_n;
	btlc_pkg::count_t timer_cnt_n;
	btlc_pkg::event_t ev_n;
	logic [CMP_W-1:0] hold_x;
	logic [CMP_W-1:0] on_x;

	assign hold_x = CMP_W'(regs.hold_ticks);
	assign on_x   = CMP_W'(regs.on_ticks);

	always_comb begin
		light_n     = light_q;
		pressing_n  = pressing_q;
		cycling_n   = cycling_q;
		timer_run_n = timer_run_q;
		press_cnt_n = press_cnt_q;
		timer_cnt_n = timer_cnt_q;
		ev_n        = btlc_pkg::EV_NONE;

		if (pressing_q && (press_cnt_q != '1)) begin
			press_cnt_n = press_cnt_q + 1'b1;
		end
		if (timer_run_q && (timer_cnt_q != '1)) begin
			timer_cnt_n = timer_cnt_q + 1'b1;
		end

		if (btn) begin
			if (!pressing_q) begin
				pressing_n  = 1'b1;
				press_cnt_n = '0;
				if (!light_q) begin
					light_n     = 1'b1;
					timer_run_n = 1'b1;
					timer_cnt_n = '0;
					ev_n        = btlc_pkg::EV_ON;
				end
				cycling_n = 1'b0;
			end
			if (CMP_W'(press_cnt_n) >= hold_x) begin
				light_n = !light_n;
				if (light_n) begin
					timer_run_n = 1'b1;
					timer_cnt_n = '0;
					ev_n        = btlc_pkg::EV_CYCLE_ON;
				end else begin
					timer_run_n = 1'b0;
					ev_n        = btlc_pkg::EV_CYCLE_OFF;
				end
				press_cnt_n = '0;
				cycling_n   = 1'b1;
			end
		end else if (pressing_q) begin
			if ((CMP_W'(press_cnt_n) < hold_x) && !cycling_q && light_q) begin
				timer_run_n = 1'b1;
				timer_cnt_n = '0;
				ev_n        = btlc_pkg::EV_RESTART;
			end
			pressing_n  = 1'b0;
			press_cnt_n = '0;
			cycling_n   = 1'b0;
		end

		if (timer_run_n && (CMP_W'(timer_cnt_n) >= on_x)) begin
			if (light_n) begin
				light_n = 1'b0;
				ev_n    = btlc_pkg::EV_TIMEOUT;
			end
			timer_run_n = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			light_q     <= 1'b0;
			pressing_q  <= 1'b0;
			cycling_q   <= 1'b0;
			timer_run_q <= 1'b0;
			press_cnt_q <= '0;
			timer_cnt_q <= '0;
		end else if (step) begin
			light_q     <= light_n;
			pressing_q  <= pressing_n;
			cycling_q   <= cycling_n;
			timer_run_q <= timer_run_n;
			press_cnt_q <= press_cnt_n;
			timer_cnt_q <= timer_cnt_n;
		end
	end

	assign res.light_on   = light_n;
	assign res.event_code = ev_n;

	// The timer only runs while the light is on.
	a_timer_light: assert property (@(posedge clk) disable iff (!arst_n)
		timer_run_q |-> light_q)
		else $error("timer running with the light off");

	// Cycle mode exists only inside a press.
	a_cycle_press: assert property (@(posedge clk) disable iff (!arst_n)
		cycling_q |-> pressing_q)
		else $error("cycle mode outside a press");

	// The press counter is cleared whenever no press is in progress.
	a_press_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!pressing_q |-> (press_cnt_q == '0))
		else $error("press count kept after release");

	// A timeout leaves the light off and the timer stopped.
	a_timeout: assert property (@(posedge clk) disable iff (!arst_n)
		(step && (ev_n == btlc_pkg::EV_TIMEOUT)) |=> (!light_q && !timer_run_q))
		else $error("timeout did not switch off");

	// An on event leaves the light on with the timer restarted.
	a_on: assert property (@(posedge clk) disable iff (!arst_n)
		(step && ((ev_n == btlc_pkg::EV_ON) || (ev_n == btlc_pkg::EV_CYCLE_ON)))
		|=> (light_q && timer_run_q && (timer_cnt_q == '0)))
		else $error("on event without light and fresh timer");

endmodule
